[src/assert_macros.svh]
// Assertion macros shared by the rate limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCRL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pcrl: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCRL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pcrl: next-cycle implication failed");

`endif

[src/pcrl_pkg.sv]
// Types and constants of the per-client rate limiter.
`default_nettype none

package pcrl_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned PERIOD_W = 30;
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned WIN_W    = PERIOD_W + BURST_W;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_TOKENS = 8'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 30'd10000000;
  localparam logic [BURST_W-1:0]  BURST_RESET  = 16'd10;

  localparam logic [1:0] VERDICT_ALLOW = 2'd0;
  localparam logic [1:0] VERDICT_RATE  = 2'd1;
  localparam logic [1:0] VERDICT_FULL  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] client_addr;
    logic [TIME_W-1:0] now_ns;
  } pcrl_req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       new_entry;
  } pcrl_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOAD,
    ST_BASE,
    ST_SUM,
    ST_DECIDE
  } pcrl_state_e;

endpackage

`default_nettype wire

[src/pcrl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module pcrl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/per_client_rate_limiter_unit.sv]
// Top level of the per-client token-bucket rate limiter.
`default_nettype none
`include "assert_macros.svh"

// Usage
//   Request channel: drive req_i and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low. busy stays high until
//   the verdict has been worked out.
//   Result channel: result_valid_o pulses for one cycle with rsp_o (verdict
//   and new_entry). The receiver cannot hold it off; capture it that cycle.
//   Configuration channel: cfg_valid_i with cfg_index_i / cfg_data_i; ready
//   is always high. Index 0 is the token period in ns, index 1 the burst in
//   tokens; other indexes are ignored. Write only while the block is idle.
// Timing
//   The client-address RAM is scanned one entry a cycle over the N clients
//   held (at most TABLE_ENTRIES). A held client then passes through the load,
//   base, sum and decide states, a new client through the base, sum and decide
//   states; a refusal on a full table is shown straight after the scan. A new
//   request can be accepted in the cycle the result is shown.
// Reset
//   Clears the fill count (the table is empty) and loads the register reset
//   values; the table RAMs need no clearing, as only filled entries are read.

module per_client_rate_limiter_unit
  import pcrl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire pcrl_req_t             req_i,
  output logic                       result_valid_o,
  output pcrl_rsp_t                  rsp_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Index width of the table and width of the fill count (holds the depth).
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  pcrl_state_e state_q, state_d;

  // Configuration registers.
  logic [PERIOD_W-1:0] period_q;
  logic [BURST_W-1:0]  burst_q;

  // Control state.
  logic [CW-1:0] used_q, used_d;
  logic          rd_pend_q, rd_pend_d;
  logic          created_q, created_d;
  logic          result_valid_q, result_valid_d;

  // Datapath registers.
  logic [CW-1:0]     scan_q, scan_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]     slot_q, slot_d;
  pcrl_req_t         req_q, req_d;
  logic [WIN_W-1:0]  window_q, window_d;
  logic [TIME_W-1:0] floor_q, floor_d;
  logic [TIME_W-1:0] due_q, due_d;
  logic [TIME_W-1:0] base_q, base_d;
  logic [TIME_W-1:0] sum_q, sum_d;
  logic              carry_q, carry_d;
  pcrl_rsp_t         rsp_q, rsp_d;

  // RAM ports.
  logic              addr_we, addr_re;
  logic [ADDR_W-1:0] addr_rdata;
  logic              due_we, due_re;
  logic [TIME_W-1:0] due_wdata, due_rdata;

  // Shared compare and arithmetic results.
  logic              hit;
  logic              scan_lt_used;
  logic              table_full;
  logic              allowed;
  logic [TIME_W:0]   floor_diff;

  assign table_full   = (used_q == CW'(TABLE_ENTRIES));
  assign scan_lt_used = (scan_q < used_q);
  assign hit          = (state_q == ST_SEARCH) && rd_pend_q &&
                        (addr_rdata == req_q.client_addr);
  assign allowed      = !carry_q && (sum_q <= req_q.now_ns);
  // Bit TIME_W is the borrow: the burst window reaches back before time zero.
  assign floor_diff   = {1'b0, req_q.now_ns} - {{(TIME_W + 1 - WIN_W){1'b0}}, window_q};

  // Client addresses, filled in index order.
  pcrl_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (used_q[IW-1:0]),
    .wdata_i (req_q.client_addr),
    .re_i    (addr_re),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (addr_rdata)
  );

  // Virtual due times of the buckets.
  pcrl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_due_ram (
    .clk_i   (clk_i),
    .we_i    (due_we),
    .waddr_i (slot_q),
    .wdata_i (due_wdata),
    .re_i    (due_re),
    .raddr_i (cmp_idx_q),
    .rdata_o (due_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_d = ST_LOAD;
        end else if (scan_lt_used) begin
          state_d = ST_SEARCH;
        end else if (table_full) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_BASE;
        end
      end
      ST_LOAD:   state_d = ST_BASE;
      ST_BASE:   state_d = ST_SUM;
      ST_SUM:    state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control per state.
  always_comb begin
    used_d         = used_q;
    rd_pend_d      = rd_pend_q;
    created_d      = created_q;
    result_valid_d = 1'b0;
    scan_d         = scan_q;
    cmp_idx_d      = cmp_idx_q;
    slot_d         = slot_q;
    req_d          = req_q;
    window_d       = window_q;
    floor_d        = floor_q;
    due_d          = due_q;
    base_d         = base_q;
    sum_d          = sum_q;
    carry_d        = carry_q;
    rsp_d          = rsp_q;
    addr_we        = 1'b0;
    addr_re        = 1'b0;
    due_we         = 1'b0;
    due_re         = 1'b0;
    due_wdata      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d     = req_i;
          window_d  = burst_q * period_q;
          scan_d    = '0;
          rd_pend_d = 1'b0;
          created_d = 1'b0;
        end
      end
      ST_SEARCH: begin
        // Clamp the window start to zero on underflow.
        floor_d = floor_diff[TIME_W] ? '0 : floor_diff[TIME_W-1:0];
        if (hit) begin
          // Fetch the bucket of the matching entry.
          due_re    = 1'b1;
          slot_d    = cmp_idx_q;
          rd_pend_d = 1'b0;
        end else if (scan_lt_used) begin
          // Issue the next address read while the previous one is compared.
          addr_re   = 1'b1;
          rd_pend_d = 1'b1;
          cmp_idx_d = scan_q[IW-1:0];
          scan_d    = scan_q + CW'(1);
        end else if (table_full) begin
          result_valid_d    = 1'b1;
          rsp_d.verdict     = VERDICT_FULL;
          rsp_d.new_entry   = 1'b0;
          rd_pend_d         = 1'b0;
        end else begin
          // Allocate the next free entry with due time zero.
          addr_we   = 1'b1;
          slot_d    = used_q[IW-1:0];
          used_d    = used_q + CW'(1);
          created_d = 1'b1;
          due_d     = '0;
          rd_pend_d = 1'b0;
        end
      end
      ST_LOAD: begin
        due_d = due_rdata;
      end
      ST_BASE: begin
        base_d = (due_q > floor_q) ? due_q : floor_q;
      end
      ST_SUM: begin
        {carry_d, sum_d} = {1'b0, base_q} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, period_q};
      end
      ST_DECIDE: begin
        result_valid_d  = 1'b1;
        rsp_d.verdict   = allowed ? VERDICT_ALLOW : VERDICT_RATE;
        rsp_d.new_entry = created_q;
        // Store the new due time, or the zero of a fresh entry that was refused.
        due_we    = allowed || created_q;
        due_wdata = allowed ? sum_q : '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      used_q         <= '0;
      rd_pend_q      <= 1'b0;
      created_q      <= 1'b0;
      result_valid_q <= 1'b0;
      period_q       <= PERIOD_RESET;
      burst_q        <= BURST_RESET;
    end else begin
      state_q        <= state_d;
      used_q         <= used_d;
      rd_pend_q      <= rd_pend_d;
      created_q      <= created_d;
      result_valid_q <= result_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TOKEN_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_BURST_TOKENS: burst_q  <= cfg_data_i[BURST_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    req_q     <= req_d;
    window_q  <= window_d;
    floor_q   <= floor_d;
    due_q     <= due_d;
    base_q    <= base_d;
    sum_q     <= sum_d;
    carry_q   <= carry_d;
    rsp_q     <= rsp_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;
  assign cfg_ready_o    = 1'b1;

  `PCRL_ASSERT_IMP(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= CW'(TABLE_ENTRIES))
  `PCRL_ASSERT_NXT(a_decide_result, clk_i, rst_ni, state_q == ST_DECIDE, result_valid_o && !busy)
  `PCRL_ASSERT_IMP(a_full_verdict, clk_i, rst_ni, result_valid_o && rsp_o.verdict == VERDICT_FULL, table_full && !rsp_o.new_entry)
  `PCRL_ASSERT_IMP(a_new_entry_used, clk_i, rst_ni, result_valid_o && rsp_o.new_entry, used_q != '0)
  `PCRL_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)

endmodule

`default_nettype wire
